FILE: hw/rtl/gss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gss_pkg;

  localparam int unsigned DATA_WIDTH = 64;
  localparam int unsigned RATIO_W    = 64;
  localparam int unsigned COUNT_W    = 63;
  localparam int unsigned SUM_W      = 64;
  localparam int unsigned HALF_LO    = DATA_WIDTH / 2;
  localparam int unsigned HALF_HI    = DATA_WIDTH - HALF_LO;
  localparam int unsigned BIT_CNT_W  = $clog2(COUNT_W + 1);

  typedef enum logic [1:0] {
    OP_SUM_SQ,
    OP_POW_SQ,
    OP_SUM_R,
    OP_POW_R
  } op_e;

  typedef struct packed {
    logic load;
    logic shift;
    logic mul_start;
    op_e  op;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_msb;
    logic bits_one;
    logic mul_done;
    logic out_full;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/gss_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface gss_in_if import gss_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [RATIO_W-1:0] ratio;
  logic [COUNT_W-1:0]        term_count;

  modport source (output valid, output ratio, output term_count, input ready);
  modport sink (input valid, input ratio, input term_count, output ready);
endinterface

interface gss_out_if import gss_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] series_sum;

  modport source (output valid, output series_sum, input ready);
  modport sink (input valid, input series_sum, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/geometric_series_sum.sv
// Geometric series sum: series_sum = 1 + ratio + ... + ratio^(term_count-1), mod 2^64.
// Input transactions arrive on in_i (ratio, term_count), one result transaction per
// input leaves on out_o (series_sum). term_count of zero returns zero.
// One item is processed at a time; in_i.ready is high only while the controller idles.
// The processing time is set by the single 32x32 multiplier: each 64-bit product takes
// three partial products plus issue and write-back, two products per bit of term_count
// below its top set bit, four where the bit is one. Leading zeros are dropped one bit
// per cycle.
// The result sits in an output register; if out_o.ready is low the next input is
// still accepted and computed, and only the hand-over of the following result waits.
// Reset (rst_ni low, asynchronous) returns the controller to idle and drops any
// pending result.
`timescale 1ns / 1ps
`default_nettype none

module geometric_series_sum import gss_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  gss_in_if.sink    in_i,
  gss_out_if.source out_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;
  logic       out_valid;
  logic [SUM_W-1:0] series_sum;

  gss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gss_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ratio_i      (in_i.ratio),
    .term_count_i (in_i.term_count),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_o.ready),
    .series_sum_o (series_sum)
  );

  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_valid;
  assign out_o.series_sum = series_sum;

endmodule

`default_nettype wire

FILE: hw/rtl/gss_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module gss_ctrl import gss_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ALIGN = 5'b00010,
    ST_ISSUE = 5'b00100,
    ST_WAIT  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic   next_bit;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    next_bit      = 1'b0;
    cmd_o.load      = 1'b0;
    cmd_o.shift     = 1'b0;
    cmd_o.mul_start = 1'b0;
    cmd_o.op        = op_q;
    cmd_o.emit      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        // drop leading zeros, then consume the top set bit
        if (status_i.count_zero) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.shift = 1'b1;
          if (status_i.count_msb) begin
            if (status_i.bits_one) begin
              state_d = ST_DONE;
            end else begin
              op_d    = OP_SUM_SQ;
              state_d = ST_ISSUE;
            end
          end
        end
      end
      ST_ISSUE: begin
        cmd_o.mul_start = 1'b1;
        state_d         = ST_WAIT;
      end
      ST_WAIT: begin
        if (status_i.mul_done) begin
          unique case (op_q)
            OP_SUM_SQ: begin
              op_d    = OP_POW_SQ;
              state_d = ST_ISSUE;
            end
            OP_POW_SQ: begin
              if (status_i.count_msb) begin
                op_d    = OP_SUM_R;
                state_d = ST_ISSUE;
              end else begin
                next_bit = 1'b1;
              end
            end
            OP_SUM_R: begin
              op_d    = OP_POW_R;
              state_d = ST_ISSUE;
            end
            OP_POW_R: begin
              next_bit = 1'b1;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
          if (next_bit) begin
            cmd_o.shift = 1'b1;
            if (status_i.bits_one) begin
              state_d = ST_DONE;
            end else begin
              op_d    = OP_SUM_SQ;
              state_d = ST_ISSUE;
            end
          end
        end
      end
      ST_DONE: begin
        if (!status_i.out_full) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_SUM_SQ;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/gss_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module gss_dp import gss_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [RATIO_W-1:0] ratio_i,
  input  logic [COUNT_W-1:0] term_count_i,
  input  ctrl_cmd_t          cmd_i,
  output dp_status_t         status_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [SUM_W-1:0]   series_sum_o
);

  typedef enum logic [4:0] {
    M_IDLE = 5'b00001,
    M_P0   = 5'b00010,
    M_P1   = 5'b00100,
    M_P2   = 5'b01000,
    M_WB   = 5'b10000
  } mul_phase_e;

  mul_phase_e phase_q, phase_d;

  logic [DATA_WIDTH-1:0] ratio_q, ratio_d;
  logic [COUNT_W-1:0]    count_q, count_d;
  logic [BIT_CNT_W-1:0]  bits_q, bits_d;
  logic [DATA_WIDTH-1:0] sum_q, sum_d;
  logic [DATA_WIDTH-1:0] pow_q, pow_d;
  logic [DATA_WIDTH-1:0] opa_q, opa_d;
  logic [DATA_WIDTH-1:0] opb_q, opb_d;
  logic [DATA_WIDTH-1:0] acc_q, acc_d;
  op_e                   dest_q, dest_d;
  logic                  out_valid_q, out_valid_d;
  logic [SUM_W-1:0]      out_sum_q, out_sum_d;

  logic [HALF_HI-1:0]   mul_x, mul_y;
  logic [2*HALF_HI-1:0] prod;

  // one shared half-width multiplier, low word built from three partial products
  always_comb begin
    unique case (phase_q)
      M_P1: begin
        mul_x = HALF_HI'(opa_q[HALF_LO-1:0]);
        mul_y = opb_q[DATA_WIDTH-1:HALF_LO];
      end
      M_P2: begin
        mul_x = opa_q[DATA_WIDTH-1:HALF_LO];
        mul_y = HALF_HI'(opb_q[HALF_LO-1:0]);
      end
      default: begin
        mul_x = HALF_HI'(opa_q[HALF_LO-1:0]);
        mul_y = HALF_HI'(opb_q[HALF_LO-1:0]);
      end
    endcase
    prod = mul_x * mul_y;
  end

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    opa_d   = opa_q;
    opb_d   = opb_q;
    dest_d  = dest_q;
    ratio_d = ratio_q;
    count_d = count_q;
    bits_d  = bits_q;
    sum_d   = sum_q;
    pow_d   = pow_q;

    unique case (phase_q)
      M_IDLE: begin
        if (cmd_i.mul_start) begin
          phase_d = M_P0;
          dest_d  = cmd_i.op;
          unique case (cmd_i.op)
            OP_SUM_SQ: begin
              opa_d = sum_q;
              opb_d = pow_q + DATA_WIDTH'(1);
            end
            OP_POW_SQ: begin
              opa_d = pow_q;
              opb_d = pow_q;
            end
            OP_SUM_R: begin
              opa_d = ratio_q;
              opb_d = sum_q;
            end
            OP_POW_R: begin
              opa_d = pow_q;
              opb_d = ratio_q;
            end
            default: begin
              opa_d = pow_q;
              opb_d = pow_q;
            end
          endcase
        end
      end
      M_P0: begin
        acc_d   = prod[DATA_WIDTH-1:0];
        phase_d = M_P1;
      end
      M_P1: begin
        acc_d   = acc_q + {prod[HALF_HI-1:0], {HALF_LO{1'b0}}};
        phase_d = M_P2;
      end
      M_P2: begin
        acc_d   = acc_q + {prod[HALF_HI-1:0], {HALF_LO{1'b0}}};
        phase_d = M_WB;
      end
      M_WB: begin
        phase_d = M_IDLE;
        if (dest_q == OP_SUM_SQ || dest_q == OP_SUM_R) begin
          sum_d = acc_q + DATA_WIDTH'(dest_q == OP_SUM_R);
        end else begin
          pow_d = acc_q;
        end
      end
      default: begin
        phase_d = M_IDLE;
      end
    endcase

    if (cmd_i.load) begin
      ratio_d = ratio_i[DATA_WIDTH-1:0];
      pow_d   = ratio_i[DATA_WIDTH-1:0];
      count_d = term_count_i;
      bits_d  = BIT_CNT_W'(COUNT_W);
      sum_d   = DATA_WIDTH'(term_count_i != '0);
    end else if (cmd_i.shift) begin
      count_d = {count_q[COUNT_W-2:0], 1'b0};
      bits_d  = bits_q - BIT_CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_sum_d   = out_sum_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_sum_d   = SUM_W'(signed'(sum_q));
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign status_o.count_zero = (count_q == '0);
  assign status_o.count_msb  = count_q[COUNT_W-1];
  assign status_o.bits_one   = (bits_q == BIT_CNT_W'(1));
  assign status_o.mul_done   = (phase_q == M_WB);
  assign status_o.out_full   = out_valid_q & ~out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign series_sum_o = out_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= M_IDLE;
      out_valid_q <= 1'b0;
      bits_q      <= '0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      bits_q      <= bits_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ratio_q   <= ratio_d;
    count_q   <= count_d;
    sum_q     <= sum_d;
    pow_q     <= pow_d;
    opa_q     <= opa_d;
    opb_q     <= opb_d;
    acc_q     <= acc_d;
    dest_q    <= dest_d;
    out_sum_q <= out_sum_d;
  end

endmodule

`default_nettype wire

FILE: test/geometric_series_sum_tb.sv
`timescale 1ns / 1ps

module geometric_series_sum_tb import gss_pkg::*; ();

  localparam int unsigned ITEM_TOTAL = 850;
  localparam int unsigned QUIET_FROM = 760;
  localparam int unsigned PAUSE_AT   = 420;
  localparam int unsigned DRAIN_WAIT = 1300;

  typedef struct {
    logic signed [RATIO_W-1:0] ratio;
    logic [COUNT_W-1:0]        term_count;
  } term_item_t;

  class series_board;
    typedef struct {
      logic signed [RATIO_W-1:0] ratio;
      logic [COUNT_W-1:0]        term_count;
      logic signed [SUM_W-1:0]   series_sum;
    } awaited_t;

    awaited_t    awaited_sums[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    // MSB-first doubling walk over the count bits, all arithmetic at DATA_WIDTH
    function logic signed [SUM_W-1:0] geo_sum(logic [RATIO_W-1:0] ratio,
                                              logic [COUNT_W-1:0] count);
      logic [DATA_WIDTH-1:0] r;
      logic [DATA_WIDTH-1:0] s;
      logic [DATA_WIDTH-1:0] p;
      int top;
      r = ratio[DATA_WIDTH-1:0];
      if (count == '0) begin
        return '0;
      end
      top = COUNT_W - 1;
      while (top > 0 && !count[top]) top--;
      s = 1;
      p = r;
      for (int b = top - 1; b >= 0; b--) begin
        s = s * (p + 1'b1);
        p = p * p;
        if (count[b]) begin
          s = s * r + 1'b1;
          p = p * r;
        end
      end
      return $signed(s);
    endfunction

    function void note_input(logic signed [RATIO_W-1:0] ratio, logic [COUNT_W-1:0] count);
      awaited_t a;
      a.ratio      = ratio;
      a.term_count = count;
      a.series_sum = geo_sum(ratio, count);
      awaited_sums.push_back(a);
    endfunction

    function void check(logic signed [SUM_W-1:0] actual);
      awaited_t a;
      if (awaited_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result transaction, series_sum=%0d", actual);
        return;
      end
      a = awaited_sums.pop_front();
      if (actual !== a.series_sum) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: ratio=%0d term_count=%0d series_sum exp %0d got %0d",
                   a.ratio, a.term_count, a.series_sum, actual);
      end
    endfunction

    function int pending_count();
      return awaited_sums.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   quiet;

  series_board board;

  gss_in_if  in_if ();
  gss_out_if out_if ();

  geometric_series_sum dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [COUNT_W-1:0] pick_count();
    logic [63:0]        raw;
    logic [COUNT_W-1:0] n;
    int                 k;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: n = '0;
      1: n = raw[COUNT_W-1:0];
      2: n = COUNT_W'($urandom_range(1, 16));
      default: begin
        k = $urandom_range(0, COUNT_W - 1);
        n = raw[COUNT_W-1:0] & ((COUNT_W'(1) << (k + 1)) - 1'b1);
        n[k] = 1'b1;
      end
    endcase
    return n;
  endfunction

  function automatic logic signed [RATIO_W-1:0] pick_ratio();
    logic signed [RATIO_W-1:0] r;
    case ($urandom_range(0, 7))
      0: r = $signed(RATIO_W'($urandom_range(0, 8))) - 4;
      1: begin
        case ($urandom_range(0, 3))
          0: r = {1'b1, {(RATIO_W-1){1'b0}}};
          1: r = {1'b0, {(RATIO_W-1){1'b1}}};
          2: r = '0;
          default: r = '1;
        endcase
      end
      default: r = {$urandom, $urandom};
    endcase
    return r;
  endfunction

  task automatic send_term(input term_item_t it);
    int gap;
    if (!quiet && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 8);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.ratio      <= it.ratio;
    in_if.term_count <= it.term_count;
    do @(posedge clk_i); while (!in_if.ready);
    board.note_input(it.ratio, it.term_count);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (board.pending_count() != 0);
  endtask

  // result side back-pressure
  initial begin
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      board.check(out_if.series_sum);
  end

  initial begin
    term_item_t directed[$];
    term_item_t it;
    logic [COUNT_W-1:0]        all_ones;
    logic signed [RATIO_W-1:0] r_min;
    logic signed [RATIO_W-1:0] r_max;

    board            = new();
    quiet            = 1'b0;
    rst_ni           = 1'b0;
    in_if.valid      <= 1'b0;
    in_if.ratio      <= '0;
    in_if.term_count <= '0;

    all_ones = '1;
    r_min    = {1'b1, {(RATIO_W-1){1'b0}}};
    r_max    = {1'b0, {(RATIO_W-1){1'b1}}};

    // zero terms, single term, wrap-around and field extremes
    directed.push_back('{'0, '0});
    directed.push_back('{r_min, '0});
    directed.push_back('{-64'sd1, '0});
    directed.push_back('{'0, COUNT_W'(1)});
    directed.push_back('{r_max, COUNT_W'(1)});
    directed.push_back('{-64'sd1, COUNT_W'(1)});
    directed.push_back('{'0, COUNT_W'(2)});
    directed.push_back('{64'sd1, all_ones});
    directed.push_back('{-64'sd1, all_ones});
    directed.push_back('{-64'sd1, COUNT_W'(1) << (COUNT_W - 1)});
    directed.push_back('{64'sd1, COUNT_W'(1) << (COUNT_W - 1)});
    directed.push_back('{64'sd2, COUNT_W'(64)});
    directed.push_back('{64'sd2, COUNT_W'(63)});
    directed.push_back('{-64'sd2, COUNT_W'(5)});
    directed.push_back('{64'sd3, COUNT_W'(40)});
    directed.push_back('{r_min, COUNT_W'(3)});
    directed.push_back('{r_min, all_ones});
    directed.push_back('{r_max, all_ones});
    directed.push_back('{r_max, COUNT_W'(2)});
    directed.push_back('{{$urandom, $urandom}, all_ones});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_term(directed[i]);

    for (int i = 0; i < ITEM_TOTAL; i++) begin
      if (i == PAUSE_AT) wait_drained();
      if (i == QUIET_FROM) quiet = 1'b1;
      it.ratio      = pick_ratio();
      it.term_count = pick_count();
      send_term(it);
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending_count() == 0) begin
      $display("geometric_series_sum: match");
    end else begin
      $display("geometric_series_sum: mismatch");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("ERROR: timed out");
    $display("geometric_series_sum: mismatch");
    $finish;
  end

endmodule
